/* rtl/icmp_pkg.sv */
// shared types and constants of the icmp echo request builder
`default_nettype none
package icmp_pkg;

	localparam int unsigned HDR_BYTES   = 8;
	localparam int unsigned ALPHA_COUNT = 26;
	localparam logic [7:0]  LETTER_BASE = 8'h41;
	localparam logic [7:0]  ECHO_TYPE   = 8'h08;
	localparam logic [7:0]  ECHO_CODE   = 8'h00;

	// one request after the checksum pass, handed from front to back
	typedef struct packed {
		logic [15:0] ident;
		logic [15:0] seq;
		logic [5:0]  len;
		logic [15:0] cks;
	} desc_t;

	typedef enum logic [2:0] {
		FR_IDLE = 3'b001,
		FR_SUM  = 3'b010,
		FR_PUSH = 3'b100
	} front_state_t;

endpackage
`default_nettype wire

/* rtl/icmp_front.sv */
// front part: accepts a request and runs the checksum pass one word a cycle
`default_nettype none
module icmp_front #(
	parameter int MAX_PAYLOAD = 56
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [15:0]    packet_id,
	input  wire logic [15:0]    sequence_number,
	input  wire logic [5:0]     payload_length,
	output logic                desc_valid,
	input  wire logic           desc_ready,
	output icmp_pkg::desc_t     desc
);
	import icmp_pkg::*;

	localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD);

	front_state_t state_q;
	logic [1:0]  phase_q;
	logic [5:0]  idx_q;
	logic [4:0]  letter_q;
	logic [16:0] acc_q;
	logic [15:0] ident_q;
	logic [15:0] seq_q;
	logic [5:0]  len_q;

	logic [15:0] word;
	logic [7:0]  lo_byte;
	logic [17:0] sum;
	logic [16:0] acc_next;
	logic [15:0] folded;
	logic        accept;

	assign accept = push && !full;
	assign full = (state_q != FR_IDLE);

	always_comb begin
		lo_byte = 8'h00;
		if ((7'(idx_q) + 7'd1) < 7'(len_q)) begin
			lo_byte = LETTER_BASE + 8'(letter_q) + 8'd1;
		end
		case (phase_q)
			2'd0:    word = ident_q;
			2'd1:    word = seq_q;
			default: word = {LETTER_BASE + 8'(letter_q), lo_byte};
		endcase
		sum = {1'b0, acc_q} + {2'b00, word};
		acc_next = 17'(sum[15:0]) + 17'(sum[17:16]);
		// the running sum never exceeds 17'h10001, so one fold is enough
		folded = acc_q[15:0] + 16'(acc_q[16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			phase_q <= 2'd0;
			idx_q <= '0;
			letter_q <= '0;
			acc_q <= '0;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (accept) begin
						state_q <= FR_SUM;
						phase_q <= 2'd0;
						idx_q <= '0;
						letter_q <= '0;
						acc_q <= {1'b0, ECHO_TYPE, 8'h00};
					end
				end
				FR_SUM: begin
					if (phase_q != 2'd2) begin
						acc_q <= acc_next;
						phase_q <= phase_q + 2'd1;
					end else if (idx_q < len_q) begin
						acc_q <= acc_next;
						idx_q <= idx_q + 6'd2;
						letter_q <= (letter_q == 5'(ALPHA_COUNT - 2)) ? 5'd0 : letter_q + 5'd2;
					end else begin
						state_q <= FR_PUSH;
					end
				end
				FR_PUSH: begin
					if (desc_ready) begin
						state_q <= FR_IDLE;
					end
				end
				default: state_q <= FR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ident_q <= packet_id;
			seq_q <= sequence_number;
			len_q <= (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
		end
	end

	assign desc_valid = (state_q == FR_PUSH);
	assign desc = '{ident: ident_q, seq: seq_q, len: len_q, cks: ~folded};

endmodule
`default_nettype wire

/* rtl/icmp_queue.sv */
// two-entry queue of checked requests between front and back
`default_nettype none
module icmp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire icmp_pkg::desc_t wr_data,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output icmp_pkg::desc_t     rd_data
);
	import icmp_pkg::*;

	desc_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/icmp_back.sv */
// back part: emits header and pattern bytes into the result register
`default_nettype none
module icmp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           desc_valid,
	output logic                desc_take,
	input  wire icmp_pkg::desc_t desc,
	output logic                empty,
	input  wire logic           pop,
	output logic [7:0]          out_byte,
	output logic                last_byte
);
	import icmp_pkg::*;

	desc_t      cur_q;
	logic       busy_q;
	logic [6:0] pos_q;
	logic [4:0] letter_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;

	logic       advance;
	logic [7:0] next_byte;
	logic       is_last;
	logic [6:0] total;

	assign desc_take = desc_valid && !busy_q;
	assign advance = busy_q && (!ovalid_q || pop);
	assign total = 7'(HDR_BYTES) + 7'(cur_q.len);
	assign is_last = (pos_q == total - 7'd1);

	always_comb begin
		next_byte = LETTER_BASE + 8'(letter_q);
		if (pos_q < 7'(HDR_BYTES)) begin
			unique case (pos_q[2:0])
				3'd0: next_byte = ECHO_TYPE;
				3'd1: next_byte = ECHO_CODE;
				3'd2: next_byte = cur_q.cks[15:8];
				3'd3: next_byte = cur_q.cks[7:0];
				3'd4: next_byte = cur_q.ident[15:8];
				3'd5: next_byte = cur_q.ident[7:0];
				3'd6: next_byte = cur_q.seq[15:8];
				3'd7: next_byte = cur_q.seq[7:0];
				default: next_byte = ECHO_TYPE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
			letter_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (desc_take) begin
				busy_q <= 1'b1;
				pos_q <= '0;
				letter_q <= '0;
			end else if (advance) begin
				if (is_last) begin
					busy_q <= 1'b0;
					pos_q <= '0;
					letter_q <= '0;
				end else begin
					pos_q <= pos_q + 7'd1;
					if (pos_q >= 7'(HDR_BYTES)) begin
						letter_q <= (letter_q == 5'(ALPHA_COUNT - 1)) ? 5'd0 : letter_q + 5'd1;
					end
				end
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_take) begin
			cur_q <= desc;
		end
		if (advance) begin
			obyte_q <= next_byte;
			olast_q <= is_last;
		end
	end

	assign empty = !ovalid_q;
	assign out_byte = obyte_q;
	assign last_byte = olast_q;

endmodule
`default_nettype wire

/* rtl/icmp_echo_request_builder.sv */
// top level of the icmp echo request builder
// Each request (identifier, sequence number, payload length, saturated to
// MAX_PAYLOAD) becomes one ICMP echo request message of 8 + length bytes,
// delivered one byte per pop with last_byte set on the final byte. The front
// part sums one 16-bit word a cycle, and a request holds full until its
// checksum pass is done and there is room in the two-entry request queue.
// The back part emits one byte a cycle from its result register while pop is
// held high, and it loads the next request once the last byte has gone; this
// emission is what sets the sustained rate. The checksum of the next request
// is computed while the current one is still being sent.
`default_nettype none
module icmp_echo_request_builder #(
	parameter int MAX_PAYLOAD = 56
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] packet_id,
	input  wire logic [15:0] sequence_number,
	input  wire logic [5:0]  payload_length,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_byte
);
	import icmp_pkg::*;

	desc_t f_desc;
	desc_t q_desc;
	logic  f_valid;
	logic  f_ready;
	logic  q_valid;
	logic  q_take;

	icmp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.packet_id(packet_id),
		.sequence_number(sequence_number),
		.payload_length(payload_length),
		.desc_valid(f_valid),
		.desc_ready(f_ready),
		.desc(f_desc)
	);

	icmp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data(f_desc),
		.rd_valid(q_valid),
		.rd_ready(q_take),
		.rd_data(q_desc)
	);

	icmp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(q_valid),
		.desc_take(q_take),
		.desc(q_desc),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_byte(last_byte)
	);

endmodule
`default_nettype wire

/* rtl/icmp_checker.sv */
// port-level checks of the icmp echo request builder and their bind
`default_nettype none
module icmp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic [15:0] packet_id,
	input wire logic [15:0] sequence_number,
	input wire logic [5:0]  payload_length,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  out_byte,
	input wire logic        last_byte
);
	import icmp_pkg::*;

	// the front is busy with a request right after taking it
	a_busy_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("full low right after an accepted request");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(last_byte))
		else $error("waiting result changed before pop");

	// inside a message the next byte follows with no gap
	a_no_gap_mid_message: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_byte |=> !empty)
		else $error("gap inside a message");

	// a message that starts after an empty output opens with the echo request type byte
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> out_byte == ECHO_TYPE && !last_byte)
		else $error("message does not start with the type byte");

endmodule

bind icmp_echo_request_builder icmp_checker u_chk (.*);
`default_nettype wire
